// ===== src/swd_pkg.sv =====
// shared types, codes and constants of the swd host transfer engine
// no dependencies; used by every module of the block
package swd_pkg;

    localparam int DEF_LINE_RESET_CLOCKS = 52;
    localparam int DEF_QUEUE_DEPTH       = 4;

    localparam int BIT_COUNT_W   = 6;
    localparam int HEADER_BITS   = 8;
    localparam int DATA_BITS     = 32;
    localparam int ACK_BITS      = 3;
    localparam int SWITCH_BITS   = 16;
    localparam int LR_LOW_CLOCKS = 2;
    localparam int RETRY_W       = 8;

    localparam logic [SWITCH_BITS-1:0] SWITCH_CODE       = 16'hE79E;
    localparam logic [RETRY_W-1:0]     RETRIES_RESET     = 8'd8;

    localparam logic [1:0] OP_XFER    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_CONNECT = 2'd2;

    localparam logic [ACK_BITS-1:0] ACK_OK   = 3'd1;
    localparam logic [ACK_BITS-1:0] ACK_WAIT = 3'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IO_ERR  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        KIND_XFER,
        KIND_TICK,
        KIND_CONNECT,
        KIND_NONE
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LR_HIGH,
        PH_LR_LOW,
        PH_SWITCH,
        PH_HEADER,
        PH_TURN_A,
        PH_ACK,
        PH_TURN_B,
        PH_DATA_IN,
        PH_PAR_IN,
        PH_TURN_END,
        PH_DATA_OUT,
        PH_PAR_OUT,
        PH_LR2_HIGH,
        PH_LR2_LOW
    } phase_t;

    typedef struct packed {
        kind_t                  kind;
        logic [HEADER_BITS-1:0] header;
        logic                   is_read;
        logic [DATA_BITS-1:0]   write_data;
        logic                   swdio_in;
    } item_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic [ACK_BITS-1:0]  last_ack;
        logic [1:0]           status;
        logic                 done_res;
        logic                 busy_res;
        logic                 clock_active;
        logic                 swdio_oe;
        logic                 swdio_out;
    } res_t;

endpackage

// ===== src/swd_host_transfer_engine.sv =====
// top level of the swd host transfer engine: front end, item queue, wire engine
// depends on swd_pkg, swd_front, swd_fifo, swd_engine
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser op, tdata request and sampled swdio
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata drive levels, status, ack, read word
//  cfg       in   cfg_valid/cfg_ready           cfg_data max_wait_retries
//
// one item per clock sustained while the output side takes results; each accepted item gives one
// result, held in the queue and then in the registered output; the wire engine state update sets the rate
// a queue of QUEUE_DEPTH items lets the input side run while the output side stalls
// rst_n clears the queue, the engine to idle and the retry limit to 8; no clearing pass
// cfg_ready is always high
module swd_host_transfer_engine
#(
    parameter int LINE_RESET_CLOCKS = swd_pkg::DEF_LINE_RESET_CLOCKS,
    parameter int QUEUE_DEPTH       = swd_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // ap_not_dp, read_not_write, reg_addr[1:0], write_data[31:0], swdio_in, zero pad
    input  logic [39:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // swdio_out, swdio_oe, clock_active, busy_res, done_res, status[1:0],
    // last_ack[2:0], read_data[31:0], zero pad
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic            queue_full;
    logic            push;
    swd_pkg::item_t  push_item;
    logic            pop;
    logic            head_valid;
    swd_pkg::item_t  head_item;
    swd_pkg::res_t   res;

    assign cfg_ready = 1'b1;

    swd_front u_front
    (
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .op             (s_axis_tuser),
        .ap_not_dp      (s_axis_tdata[0]),
        .read_not_write (s_axis_tdata[1]),
        .reg_addr       (s_axis_tdata[3:2]),
        .write_data     (s_axis_tdata[35:4]),
        .swdio_in       (s_axis_tdata[36]),
        .queue_full     (queue_full),
        .push           (push),
        .item           (push_item)
    );

    swd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    swd_engine #(
        .LINE_RESET_CLOCKS (LINE_RESET_CLOCKS)
    ) u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    assign m_axis_tdata = {6'b0, res.read_data, res.last_ack, res.status, res.done_res,
                           res.busy_res, res.clock_active, res.swdio_oe, res.swdio_out};

endmodule

// ===== src/swd_front.sv =====
// front end: accepts input transfers, classifies the op and builds the request header
// depends on swd_pkg
module swd_front
(
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic                 ap_not_dp,
    input  logic                 read_not_write,
    input  logic [1:0]           reg_addr,
    input  logic [31:0]          write_data,
    input  logic                 swdio_in,
    input  logic                 queue_full,
    output logic                 push,
    output swd_pkg::item_t       item
);

    logic parity;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign parity   = ap_not_dp ^ read_not_write ^ reg_addr[0] ^ reg_addr[1];

    always_comb
    begin
        case (op)
            swd_pkg::OP_XFER:    item.kind = swd_pkg::KIND_XFER;
            swd_pkg::OP_TICK:    item.kind = swd_pkg::KIND_TICK;
            swd_pkg::OP_CONNECT: item.kind = swd_pkg::KIND_CONNECT;
            default:             item.kind = swd_pkg::KIND_NONE;
        endcase
        // start, apndp, rnw, a2, a3, parity, stop, park
        item.header     = {1'b1, 1'b0, parity, reg_addr[1], reg_addr[0],
                           read_not_write, ap_not_dp, 1'b1};
        item.is_read    = read_not_write;
        item.write_data = write_data;
        item.swdio_in   = swdio_in;
    end

endmodule

// ===== src/swd_fifo.sv =====
// short queue of classified items between front end and wire engine
// depends on swd_pkg
module swd_fifo
#(
    parameter int DEPTH = swd_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  swd_pkg::item_t  push_item,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output swd_pkg::item_t  head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    swd_pkg::item_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ===== src/swd_engine.sv =====
// back end: swd wire state machine, one item per cycle while the result is not stalled, with registered result
// depends on swd_pkg
module swd_engine
#(
    parameter int LINE_RESET_CLOCKS = swd_pkg::DEF_LINE_RESET_CLOCKS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  swd_pkg::item_t              head_item,
    output logic                        pop,
    input  logic                        cfg_valid,
    input  logic [swd_pkg::RETRY_W-1:0] cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output swd_pkg::res_t               out_res
);

    localparam int BCW = swd_pkg::BIT_COUNT_W;
    localparam int DW  = swd_pkg::DATA_BITS;
    localparam int AW  = swd_pkg::ACK_BITS;
    localparam int RW  = swd_pkg::RETRY_W;

    swd_pkg::phase_t    phase_reg, phase_next;
    logic [BCW-1:0]     bit_count_reg, bit_count_next;
    logic [7:0]         header_reg, header_next;
    logic [DW-1:0]      data_reg, data_next;
    logic [AW-1:0]      ack_reg, ack_next;
    logic               parity_reg, parity_next;
    logic [RW-1:0]      retry_reg, retry_next;
    logic               is_read_reg, is_read_next;
    logic [RW-1:0]      max_retries_reg;
    logic               out_valid_reg;
    swd_pkg::res_t      out_res_reg;
    swd_pkg::res_t      res;

    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        logic [BCW-1:0] bc_inc;
        logic [AW-1:0]  ack_new;
        logic [RW-1:0]  retry_inc;
        logic           din;

        bc_inc    = bit_count_reg + 1'b1;
        din       = head_item.swdio_in;
        ack_new   = ack_reg | (AW'(din) << bit_count_reg[1:0]);
        retry_inc = retry_reg + 1'b1;

        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        header_next    = header_reg;
        data_next      = data_reg;
        ack_next       = ack_reg;
        parity_next    = parity_reg;
        retry_next     = retry_reg;
        is_read_next   = is_read_reg;
        res            = '0;
        res.swdio_oe   = 1'b1;

        if (head_item.kind == swd_pkg::KIND_XFER && phase_reg == swd_pkg::PH_IDLE)
        begin
            is_read_next   = head_item.is_read;
            header_next    = head_item.header;
            data_next      = head_item.write_data;
            retry_next     = '0;
            parity_next    = 1'b0;
            bit_count_next = '0;
            phase_next     = swd_pkg::PH_HEADER;
        end
        else if (head_item.kind == swd_pkg::KIND_CONNECT && phase_reg == swd_pkg::PH_IDLE)
        begin
            bit_count_next = '0;
            phase_next     = swd_pkg::PH_LR_HIGH;
        end
        else if (head_item.kind == swd_pkg::KIND_TICK && phase_reg != swd_pkg::PH_IDLE)
        begin
            res.clock_active = 1'b1;
            case (phase_reg)
                swd_pkg::PH_LR_HIGH, swd_pkg::PH_LR2_HIGH:
                begin
                    res.swdio_out  = 1'b1;
                    bit_count_next = bc_inc;
                    if (bc_inc >= BCW'(LINE_RESET_CLOCKS))
                    begin
                        phase_next = (phase_reg == swd_pkg::PH_LR_HIGH) ?
                                     swd_pkg::PH_LR_LOW : swd_pkg::PH_LR2_LOW;
                        bit_count_next = '0;
                    end
                end
                swd_pkg::PH_LR_LOW, swd_pkg::PH_LR2_LOW:
                begin
                    bit_count_next = bc_inc;
                    if (bc_inc >= BCW'(swd_pkg::LR_LOW_CLOCKS))
                    begin
                        bit_count_next = '0;
                        if (phase_reg == swd_pkg::PH_LR_LOW)
                        begin
                            phase_next = swd_pkg::PH_SWITCH;
                        end
                        else
                        begin
                            phase_next   = swd_pkg::PH_IDLE;
                            res.done_res = 1'b1;
                            res.status   = swd_pkg::ST_OK;
                        end
                    end
                end
                swd_pkg::PH_SWITCH:
                begin
                    res.swdio_out  = swd_pkg::SWITCH_CODE[bit_count_reg[3:0]];
                    bit_count_next = bc_inc;
                    if (bc_inc >= BCW'(swd_pkg::SWITCH_BITS))
                    begin
                        phase_next     = swd_pkg::PH_LR2_HIGH;
                        bit_count_next = '0;
                    end
                end
                swd_pkg::PH_HEADER:
                begin
                    res.swdio_out  = header_reg[bit_count_reg[2:0]];
                    bit_count_next = bc_inc;
                    if (bc_inc >= BCW'(swd_pkg::HEADER_BITS))
                    begin
                        phase_next     = swd_pkg::PH_TURN_A;
                        bit_count_next = '0;
                    end
                end
                swd_pkg::PH_TURN_A:
                begin
                    res.swdio_oe   = 1'b0;
                    phase_next     = swd_pkg::PH_ACK;
                    bit_count_next = '0;
                    ack_next       = '0;
                end
                swd_pkg::PH_ACK:
                begin
                    res.swdio_oe   = 1'b0;
                    ack_next       = ack_new;
                    bit_count_next = bc_inc;
                    if (bc_inc >= BCW'(swd_pkg::ACK_BITS))
                    begin
                        bit_count_next = '0;
                        parity_next    = 1'b0;
                        phase_next     = (ack_new == swd_pkg::ACK_OK && is_read_reg) ?
                                         swd_pkg::PH_DATA_IN : swd_pkg::PH_TURN_B;
                    end
                end
                swd_pkg::PH_TURN_B:
                begin
                    res.swdio_oe = 1'b0;
                    if (ack_reg == swd_pkg::ACK_OK)
                    begin
                        phase_next     = swd_pkg::PH_DATA_OUT;
                        bit_count_next = '0;
                        parity_next    = 1'b0;
                    end
                    else if (ack_reg == swd_pkg::ACK_WAIT)
                    begin
                        retry_next     = retry_inc;
                        bit_count_next = '0;
                        if (retry_inc >= max_retries_reg)
                        begin
                            phase_next   = swd_pkg::PH_IDLE;
                            res.done_res = 1'b1;
                            res.status   = swd_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            phase_next = swd_pkg::PH_HEADER;
                        end
                    end
                    else
                    begin
                        phase_next     = swd_pkg::PH_IDLE;
                        bit_count_next = '0;
                        res.done_res   = 1'b1;
                        res.status     = swd_pkg::ST_IO_ERR;
                    end
                end
                swd_pkg::PH_DATA_IN:
                begin
                    res.swdio_oe   = 1'b0;
                    data_next      = {din, data_reg[DW-1:1]};
                    parity_next    = parity_reg ^ din;
                    bit_count_next = bc_inc;
                    if (bc_inc >= BCW'(DW))
                    begin
                        phase_next     = swd_pkg::PH_PAR_IN;
                        bit_count_next = '0;
                    end
                end
                swd_pkg::PH_PAR_IN:
                begin
                    res.swdio_oe = 1'b0;
                    parity_next  = din ^ parity_reg;
                    phase_next   = swd_pkg::PH_TURN_END;
                end
                swd_pkg::PH_TURN_END:
                begin
                    res.swdio_oe   = 1'b0;
                    res.read_data  = data_reg;
                    res.done_res   = 1'b1;
                    res.status     = {1'b0, parity_reg};
                    phase_next     = swd_pkg::PH_IDLE;
                    bit_count_next = '0;
                end
                swd_pkg::PH_DATA_OUT:
                begin
                    res.swdio_out  = data_reg[0];
                    parity_next    = parity_reg ^ data_reg[0];
                    data_next      = {data_reg[0], data_reg[DW-1:1]};
                    bit_count_next = bc_inc;
                    if (bc_inc >= BCW'(DW))
                    begin
                        phase_next     = swd_pkg::PH_PAR_OUT;
                        bit_count_next = '0;
                    end
                end
                swd_pkg::PH_PAR_OUT:
                begin
                    res.swdio_out  = parity_reg;
                    res.done_res   = 1'b1;
                    res.status     = swd_pkg::ST_OK;
                    phase_next     = swd_pkg::PH_IDLE;
                    bit_count_next = '0;
                end
                default:
                begin
                    phase_next       = swd_pkg::PH_IDLE;
                    bit_count_next   = '0;
                    res.clock_active = 1'b0;
                end
            endcase
        end

        res.busy_res = (phase_next != swd_pkg::PH_IDLE);
        res.last_ack = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= swd_pkg::PH_IDLE;
            bit_count_reg   <= '0;
            header_reg      <= '0;
            data_reg        <= '0;
            ack_reg         <= '0;
            parity_reg      <= 1'b0;
            retry_reg       <= '0;
            is_read_reg     <= 1'b0;
            max_retries_reg <= swd_pkg::RETRIES_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_retries_reg <= cfg_data;
            end
            if (pop)
            begin
                phase_reg     <= phase_next;
                bit_count_reg <= bit_count_next;
                header_reg    <= header_next;
                data_reg      <= data_next;
                ack_reg       <= ack_next;
                parity_reg    <= parity_next;
                retry_reg     <= retry_next;
                is_read_reg   <= is_read_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_res_reg <= res;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("result overwritten while stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res.done_res) |=> (phase_reg == swd_pkg::PH_IDLE))
        else $error("engine not idle after done");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res.status != swd_pkg::ST_OK) |-> res.done_res)
        else $error("status without done");

    a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !res.swdio_oe) |-> (!res.swdio_out && res.clock_active))
        else $error("released line driven high or unclocked");

endmodule

// ===== sim/swd_host_transfer_engine_checker.sv =====
// checker for the swd host transfer engine: watches the item, result and config channels,
// predicts the result of each accepted item and compares it field by field with the block's output
// depends on swd_pkg
module swd_host_transfer_engine_checker
#(
    parameter int LINE_RESET_CLOCKS = swd_pkg::DEF_LINE_RESET_CLOCKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          errors,
    output int          pending,
    output logic        engine_busy
);

    swd_pkg::phase_t    phase;
    int                 bit_cnt;
    logic [7:0]         header;
    logic [31:0]        shift_word;
    logic [2:0]         ack_bits;
    logic               par;
    logic [7:0]         retries;
    logic               is_read;
    logic [7:0]         retry_limit;
    swd_pkg::res_t      due_results[$];
    swd_pkg::res_t      want;
    swd_pkg::res_t      got;

    initial
    begin
        errors = 0;
        pending = 0;
        engine_busy = 1'b0;
    end

    function automatic swd_pkg::res_t wire_step(input logic [1:0] op, input logic [39:0] req);
        swd_pkg::res_t r;
        logic          din;
        logic          b;
        logic          fin;
        logic [1:0]    st;
        r = '0;
        r.swdio_oe = 1'b1;
        din = req[36];
        fin = 1'b0;
        st = swd_pkg::ST_OK;
        if (op == swd_pkg::OP_XFER && phase == swd_pkg::PH_IDLE)
        begin
            is_read = req[1];
            header = {1'b1, 1'b0, ^req[3:0], req[3:0], 1'b1};
            shift_word = req[35:4];
            retries = '0;
            par = 1'b0;
            bit_cnt = 0;
            phase = swd_pkg::PH_HEADER;
        end
        else if (op == swd_pkg::OP_CONNECT && phase == swd_pkg::PH_IDLE)
        begin
            bit_cnt = 0;
            phase = swd_pkg::PH_LR_HIGH;
        end
        else if (op == swd_pkg::OP_TICK && phase != swd_pkg::PH_IDLE)
        begin
            r.clock_active = 1'b1;
            case (phase)
                swd_pkg::PH_LR_HIGH, swd_pkg::PH_LR2_HIGH:
                begin
                    r.swdio_out = 1'b1;
                    bit_cnt++;
                    if (bit_cnt >= LINE_RESET_CLOCKS)
                    begin
                        phase = (phase == swd_pkg::PH_LR_HIGH) ?
                                swd_pkg::PH_LR_LOW : swd_pkg::PH_LR2_LOW;
                        bit_cnt = 0;
                    end
                end
                swd_pkg::PH_LR_LOW, swd_pkg::PH_LR2_LOW:
                begin
                    bit_cnt++;
                    if (bit_cnt >= swd_pkg::LR_LOW_CLOCKS)
                    begin
                        if (phase == swd_pkg::PH_LR_LOW)
                        begin
                            phase = swd_pkg::PH_SWITCH;
                            bit_cnt = 0;
                        end
                        else
                            fin = 1'b1;
                    end
                end
                swd_pkg::PH_SWITCH:
                begin
                    r.swdio_out = swd_pkg::SWITCH_CODE[4'(bit_cnt)];
                    bit_cnt++;
                    if (bit_cnt >= swd_pkg::SWITCH_BITS)
                    begin
                        phase = swd_pkg::PH_LR2_HIGH;
                        bit_cnt = 0;
                    end
                end
                swd_pkg::PH_HEADER:
                begin
                    r.swdio_out = header[3'(bit_cnt)];
                    bit_cnt++;
                    if (bit_cnt >= swd_pkg::HEADER_BITS)
                    begin
                        phase = swd_pkg::PH_TURN_A;
                        bit_cnt = 0;
                    end
                end
                swd_pkg::PH_TURN_A:
                begin
                    r.swdio_oe = 1'b0;
                    phase = swd_pkg::PH_ACK;
                    bit_cnt = 0;
                    ack_bits = '0;
                end
                swd_pkg::PH_ACK:
                begin
                    r.swdio_oe = 1'b0;
                    ack_bits[2'(bit_cnt)] = din;
                    bit_cnt++;
                    if (bit_cnt >= swd_pkg::ACK_BITS)
                    begin
                        bit_cnt = 0;
                        par = 1'b0;
                        phase = (ack_bits == swd_pkg::ACK_OK && is_read) ?
                                swd_pkg::PH_DATA_IN : swd_pkg::PH_TURN_B;
                    end
                end
                swd_pkg::PH_TURN_B:
                begin
                    r.swdio_oe = 1'b0;
                    if (ack_bits == swd_pkg::ACK_OK)
                    begin
                        phase = swd_pkg::PH_DATA_OUT;
                        bit_cnt = 0;
                        par = 1'b0;
                    end
                    else if (ack_bits == swd_pkg::ACK_WAIT)
                    begin
                        retries = retries + 8'd1;
                        if (retries >= retry_limit)
                        begin
                            fin = 1'b1;
                            st = swd_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            phase = swd_pkg::PH_HEADER;
                            bit_cnt = 0;
                        end
                    end
                    else
                    begin
                        fin = 1'b1;
                        st = swd_pkg::ST_IO_ERR;
                    end
                end
                swd_pkg::PH_DATA_IN:
                begin
                    r.swdio_oe = 1'b0;
                    shift_word = {din, shift_word[31:1]};
                    par ^= din;
                    bit_cnt++;
                    if (bit_cnt >= swd_pkg::DATA_BITS)
                    begin
                        phase = swd_pkg::PH_PAR_IN;
                        bit_cnt = 0;
                    end
                end
                swd_pkg::PH_PAR_IN:
                begin
                    r.swdio_oe = 1'b0;
                    par = (din != par);
                    phase = swd_pkg::PH_TURN_END;
                end
                swd_pkg::PH_TURN_END:
                begin
                    r.swdio_oe = 1'b0;
                    r.read_data = shift_word;
                    fin = 1'b1;
                    st = par ? swd_pkg::ST_IO_ERR : swd_pkg::ST_OK;
                end
                swd_pkg::PH_DATA_OUT:
                begin
                    b = shift_word[0];
                    r.swdio_out = b;
                    par ^= b;
                    shift_word = {b, shift_word[31:1]};
                    bit_cnt++;
                    if (bit_cnt >= swd_pkg::DATA_BITS)
                    begin
                        phase = swd_pkg::PH_PAR_OUT;
                        bit_cnt = 0;
                    end
                end
                swd_pkg::PH_PAR_OUT:
                begin
                    r.swdio_out = par;
                    fin = 1'b1;
                end
                default:
                begin
                    phase = swd_pkg::PH_IDLE;
                    bit_cnt = 0;
                    r.clock_active = 1'b0;
                end
            endcase
        end
        if (fin)
        begin
            r.done_res = 1'b1;
            r.status = st;
            phase = swd_pkg::PH_IDLE;
            bit_cnt = 0;
        end
        r.busy_res = (phase != swd_pkg::PH_IDLE);
        r.last_ack = ack_bits;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = swd_pkg::PH_IDLE;
            bit_cnt = 0;
            header = '0;
            shift_word = '0;
            ack_bits = '0;
            par = 1'b0;
            retries = '0;
            is_read = 1'b0;
            retry_limit = swd_pkg::RETRIES_RESET;
            due_results.delete();
            pending <= 0;
            engine_busy <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(swd_pkg::res_t)-1:0];
                if (due_results.size() == 0)
                begin
                    $display("%0t: result transfer, expected none actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("swdio_out", 32'(want.swdio_out), 32'(got.swdio_out));
                    check_field("swdio_oe", 32'(want.swdio_oe), 32'(got.swdio_oe));
                    check_field("clock_active", 32'(want.clock_active),
                                32'(got.clock_active));
                    check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                    check_field("done_res", 32'(want.done_res), 32'(got.done_res));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("last_ack", 32'(want.last_ack), 32'(got.last_ack));
                    check_field("read_data", want.read_data, got.read_data);
                end
            end
            if (cfg_valid && cfg_ready)
                retry_limit = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(wire_step(s_axis_tuser, s_axis_tdata));
            pending <= due_results.size();
            engine_busy <= (phase != swd_pkg::PH_IDLE);
        end
    end

endmodule

// ===== sim/swd_host_transfer_engine_test.sv =====
// testbench top of the swd host transfer engine: clock, reset, item and config stimulus
// with random stalls on both sides, watchdog and verdict
// depends on swd_pkg, swd_host_transfer_engine and swd_host_transfer_engine_checker
module swd_host_transfer_engine_test;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] ACK_FAULT  = 3'd4;
    localparam int STALL_PCT          = 38;
    localparam int QUIET_LIMIT        = 1000;
    localparam int SETTLE_CYCLES      = 8;
    localparam int PHASE_TICKS        = 70;
    localparam int CONNECT_TICKS      =
        2 * (swd_pkg::DEF_LINE_RESET_CLOCKS + swd_pkg::LR_LOW_CLOCKS) + swd_pkg::SWITCH_BITS;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = swd_pkg::OP_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data      = '0;

    int          errors;
    int          pending;
    logic        model_busy;
    logic        steady        = 1'b0;
    int          ticks_sent    = 0;
    int          quiet         = 0;
    logic [7:0]  limit_now     = swd_pkg::RETRIES_RESET;

    swd_host_transfer_engine #(
        .LINE_RESET_CLOCKS(swd_pkg::DEF_LINE_RESET_CLOCKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    swd_host_transfer_engine_checker #(
        .LINE_RESET_CLOCKS(swd_pkg::DEF_LINE_RESET_CLOCKS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .errors(errors),
        .pending(pending),
        .engine_busy(model_busy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("FAIL swd_host_transfer_engine");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    function automatic logic [39:0] pack_req(input logic ap, input logic rd,
                                             input logic [1:0] addr, input logic [31:0] wdata,
                                             input logic din);
        return {3'b000, din, wdata, addr, rd, ap};
    endfunction

    function automatic logic [39:0] rand_req(input logic din);
        return pack_req(1'($urandom), 1'($urandom), 2'($urandom), 32'($urandom), din);
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [39:0] payload);
        while (!steady && $urandom_range(0, 99) < STALL_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= payload;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        if (op == swd_pkg::OP_TICK)
            ticks_sent++;
    endtask

    // one wire clock, now and then preceded by a start or unused op that a busy engine ignores
    task automatic wire_tick(input logic din);
        logic [1:0] noise_op;
        if ($urandom_range(0, 19) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       noise_op = swd_pkg::OP_XFER;
                1:       noise_op = swd_pkg::OP_CONNECT;
                default: noise_op = OP_UNUSED;
            endcase
            send_item(noise_op, rand_req(1'($urandom)));
        end
        send_item(swd_pkg::OP_TICK, rand_req(din));
    endtask

    task automatic run_connect();
        send_item(swd_pkg::OP_CONNECT, rand_req(1'($urandom)));
        repeat (CONNECT_TICKS) wire_tick(1'($urandom));
    endtask

    // target side plays waits acks first, then end_ack, unless the retry limit runs out
    task automatic run_transfer(input logic rd, input int waits, input logic [2:0] end_ack);
        int         attempt_cap;
        int         n;
        int         i;
        logic [2:0] ack;
        logic       par;
        logic       b;
        attempt_cap = (limit_now == 8'd0) ? 1 : int'(limit_now);
        send_item(swd_pkg::OP_XFER, pack_req(1'($urandom), rd, 2'($urandom), 32'($urandom),
                                             1'($urandom)));
        for (n = 0; n <= waits && n < attempt_cap; n++)
        begin
            ack = (n < waits) ? swd_pkg::ACK_WAIT : end_ack;
            repeat (swd_pkg::HEADER_BITS + 1) wire_tick(1'($urandom));
            for (i = 0; i < swd_pkg::ACK_BITS; i++)
                wire_tick(ack[i]);
            if (ack == swd_pkg::ACK_OK && rd)
            begin
                par = 1'b0;
                for (i = 0; i < swd_pkg::DATA_BITS; i++)
                begin
                    b = 1'($urandom);
                    par ^= b;
                    wire_tick(b);
                end
                wire_tick(($urandom_range(0, 3) == 0) ? !par : par);
                wire_tick(1'($urandom));
            end
            else if (ack == swd_pkg::ACK_OK)
                repeat (swd_pkg::DATA_BITS + 2) wire_tick(1'($urandom));
            else
                wire_tick(1'($urandom));
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_now = value;
    endtask

    initial
    begin
        logic [7:0] limits[5];
        logic [2:0] end_ack;
        int         p;
        int         pick;
        int         waits;
        int         stop_at;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle tick, unused op at idle, all-ones write to the top address with a fault ack
        send_item(swd_pkg::OP_TICK, pack_req(1'b0, 1'b0, 2'd0, 32'h0000_0000, 1'b0));
        send_item(OP_UNUSED, pack_req(1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1));
        send_item(swd_pkg::OP_XFER, pack_req(1'b1, 1'b0, 2'd3, 32'hFFFF_FFFF, 1'b1));
        send_item(swd_pkg::OP_XFER, pack_req(1'b0, 1'b1, 2'd0, 32'h0000_0000, 1'b0));
        send_item(swd_pkg::OP_CONNECT, pack_req(1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1));
        send_item(OP_UNUSED, pack_req(1'b0, 1'b0, 2'd0, 32'h0000_0000, 1'b0));
        for (p = 0; p < swd_pkg::HEADER_BITS + 1; p++)
            send_item(swd_pkg::OP_TICK, rand_req(1'(p)));
        for (p = 0; p < swd_pkg::ACK_BITS; p++)
            send_item(swd_pkg::OP_TICK, rand_req(ACK_FAULT[p]));
        send_item(swd_pkg::OP_TICK, rand_req(1'b1));

        limits[0] = 8'd0;
        limits[1] = 8'd1;
        limits[2] = 8'd255;
        limits[3] = 8'($urandom_range(2, 254));
        limits[4] = swd_pkg::RETRIES_RESET;

        for (p = 0; p < 5; p++)
        begin
            write_limit(limits[p]);
            steady = (p == 3);
            if (p == 0)
                run_connect();
            stop_at = ticks_sent + PHASE_TICKS;
            while (ticks_sent < stop_at)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: end_ack = swd_pkg::ACK_OK;
                        6, 7:             end_ack = ACK_FAULT;
                        default:
                        begin
                            end_ack = 3'($urandom);
                            while (end_ack inside {swd_pkg::ACK_OK, swd_pkg::ACK_WAIT,
                                                   ACK_FAULT})
                                end_ack = 3'($urandom);
                        end
                    endcase
                    waits = $urandom_range(0, 9);
                    if (waits <= 5)
                        waits = 0;
                    else if (waits == 9 && limit_now <= 8'd8)
                        waits = (limit_now == 8'd0) ? 1 : int'(limit_now);
                    else
                        waits = $urandom_range(1, 3);
                    run_transfer(1'($urandom), waits, end_ack);
                end
                else if (pick == 14)
                    run_connect();
                else
                begin
                    // broken sequence of raw items, then clock the engine back to idle
                    repeat ($urandom_range(1, 6))
                        send_item(2'($urandom), rand_req(1'($urandom)));
                    while (model_busy)
                        wire_tick(1'($urandom));
                end
            end
        end

        steady = 1'b0;
        settle();
        if (errors == 0 && pending == 0)
            $display("PASS swd_host_transfer_engine");
        else
            $display("FAIL swd_host_transfer_engine");
        $finish;
    end

endmodule

// ===== files.f =====
src/swd_pkg.sv
src/swd_front.sv
src/swd_fifo.sv
src/swd_engine.sv
src/swd_host_transfer_engine.sv
sim/swd_host_transfer_engine_checker.sv
sim/swd_host_transfer_engine_test.sv
